// ===== src/u8d_pkg.sv =====
// Shared types, constants and lead-byte decode for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int CpW    = 31;
  localparam int ByteW  = 8;
  localparam int CntW   = 3;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QLvlW  = $clog2(QDepth + 1);

  typedef logic [CpW-1:0]   cp_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam cp_t ReplReset = CpW'(63);

  // Byte class tags, compared against the top bits of a byte
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;
  localparam logic [5:0] Lead5Tag = 6'b111110;
  localparam logic [6:0] Lead6Tag = 7'b1111110;

  // One result beat
  typedef struct packed {
    cp_t  code_point;
    logic replaced;
    logic run_end;
    logic text_end;
  } res_t;

  // Classification of a byte taken as a lead
  typedef struct packed {
    logic ascii;
    logic multi;
    cnt_t conts;
    cp_t  bits;
  } lead_t;

  function automatic lead_t lead_decode(byte_t b);
    lead_t l;
    l = '0;
    if (!b[7]) begin
      l.ascii = 1'b1;
    end else if (b[7:5] == Lead2Tag) begin
      l.multi = 1'b1;
      l.conts = CntW'(1);
      l.bits  = CpW'(b[4:0]);
    end else if (b[7:4] == Lead3Tag) begin
      l.multi = 1'b1;
      l.conts = CntW'(2);
      l.bits  = CpW'(b[3:0]);
    end else if (b[7:3] == Lead4Tag) begin
      l.multi = 1'b1;
      l.conts = CntW'(3);
      l.bits  = CpW'(b[2:0]);
    end else if (b[7:2] == Lead5Tag) begin
      l.multi = 1'b1;
      l.conts = CntW'(4);
      l.bits  = CpW'(b[1:0]);
    end else if (b[7:1] == Lead6Tag) begin
      l.multi = 1'b1;
      l.conts = CntW'(5);
      l.bits  = CpW'(b[0]);
    end
    return l;
  endfunction

  // Smallest value that is not overlong for a given continuation count
  function automatic cp_t overlong_floor(cnt_t c);
    cp_t f;
    case (c)
      3'd1:    f = CpW'(32'h80);
      3'd2:    f = CpW'(32'h800);
      3'd3:    f = CpW'(32'h10000);
      3'd4:    f = CpW'(32'h200000);
      3'd5:    f = CpW'(32'h4000000);
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== src/u8d_ifs.sv =====
// Channel interfaces: byte input, result output and configuration write.
interface u8d_in_if import u8d_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  final_byte;
  modport source(output valid, text_byte, final_byte, input ready);
  modport sink(input valid, text_byte, final_byte, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  code_point;
  logic replaced;
  logic run_end;
  logic text_end;
  modport source(output valid, code_point, replaced, run_end, text_end, input ready);
  modport sink(input valid, code_point, replaced, run_end, text_end, output ready);
endinterface

interface u8d_cfg_if import u8d_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  replacement_char;
  modport source(output valid, replacement_char, input ready);
  modport sink(input valid, replacement_char, output ready);
endinterface

// ===== src/u8d_step.sv =====
// Decoder state and per-byte decode producing up to two results.
module u8d_step import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire_i,
  input  byte_t      byte_i,
  input  logic       fin_i,
  input  cp_t        repl_i,
  output logic [1:0] n_o,
  output res_t       res0_o,
  output res_t       res1_o,
  output logic       busy_o
);

  cp_t  acc_r, acc_nxt;
  cnt_t rem_r, rem_nxt;
  cnt_t conts_r, conts_nxt;

  lead_t lead;
  logic  is_cont;
  logic  lead_has;
  cp_t   lead_cp;
  logic  lead_rep;
  cp_t   acc_shift;
  cnt_t  rem_dec;
  cp_t   r0_cp, r1_cp;
  logic  r0_rep, r1_rep;

  always_comb begin
    lead      = lead_decode(byte_i);
    is_cont   = (byte_i[7:6] == ContTag);
    acc_shift = {acc_r[CpW-7:0], byte_i[5:0]};
    rem_dec   = rem_r - CntW'(1);

    // Result of taking the byte as a lead
    lead_has = 1'b1;
    lead_cp  = repl_i;
    lead_rep = 1'b1;
    if (lead.ascii) begin
      lead_cp  = CpW'(byte_i);
      lead_rep = 1'b0;
    end else if (lead.multi && !fin_i) begin
      lead_has = 1'b0;
    end

    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    conts_nxt = conts_r;
    n_o       = 2'd0;
    r0_cp     = repl_i;
    r0_rep    = 1'b1;
    r1_cp     = lead_cp;
    r1_rep    = lead_rep;

    if (rem_r != '0 && is_cont) begin
      // Continuation of an open sequence
      if (rem_dec == '0) begin
        n_o       = 2'd1;
        if (acc_shift >= overlong_floor(conts_r)) begin
          r0_cp  = acc_shift;
          r0_rep = 1'b0;
        end
        acc_nxt   = '0;
        rem_nxt   = '0;
        conts_nxt = '0;
      end else if (fin_i) begin
        n_o       = 2'd1;
        acc_nxt   = '0;
        rem_nxt   = '0;
        conts_nxt = '0;
      end else begin
        acc_nxt = acc_shift;
        rem_nxt = rem_dec;
      end
    end else begin
      // Idle or broken sequence: decode the byte as a lead
      acc_nxt   = '0;
      rem_nxt   = '0;
      conts_nxt = '0;
      if (lead.multi && !fin_i) begin
        acc_nxt   = lead.bits;
        rem_nxt   = lead.conts;
        conts_nxt = lead.conts;
      end
      if (rem_r != '0) begin
        n_o = lead_has ? 2'd2 : 2'd1;
      end else if (lead_has) begin
        n_o    = 2'd1;
        r0_cp  = lead_cp;
        r0_rep = lead_rep;
      end
    end

    res0_o = '{code_point: r0_cp, replaced: r0_rep,
               run_end: (n_o == 2'd1), text_end: fin_i && (n_o == 2'd1)};
    res1_o = '{code_point: r1_cp, replaced: r1_rep,
               run_end: 1'b1, text_end: fin_i};
  end

  // Advance state on each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      rem_r   <= '0;
      conts_r <= '0;
    end else if (fire_i) begin
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      conts_r <= conts_nxt;
    end
  end

  assign busy_o = (rem_r != '0);

endmodule

// ===== src/u8d_outq.sv =====
// Result queue: takes zero to two beats per cycle, gives one per cycle while popped.
module u8d_outq import u8d_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n_i,
  input  res_t             push0_i,
  input  res_t             push1_i,
  input  logic             pop_i,
  output logic             valid_o,
  output res_t             head_o,
  output logic [QLvlW-1:0] level_o
);

  res_t             mem_r [QDepth];
  logic [QPtrW-1:0] head_r, head_nxt;
  logic [QPtrW-1:0] tail_r, tail_nxt;
  logic [QLvlW-1:0] level_r, level_nxt;
  logic             pop_ok;

  always_comb begin
    pop_ok    = pop_i && (level_r != '0);
    head_nxt  = head_r + QPtrW'(pop_ok);
    tail_nxt  = tail_r + QPtrW'(push_n_i);
    level_nxt = level_r + QLvlW'(push_n_i) - QLvlW'(pop_ok);
  end

  // Write the pushed beats at the tail
  always_ff @(posedge clk) begin
    if (push_n_i != 2'd0) begin
      mem_r[tail_r] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_r[tail_r + QPtrW'(1)] <= push1_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
    end
  end

  assign valid_o = (level_r != '0);
  assign head_o  = mem_r[head_r];
  assign level_o = level_r;

endmodule

// ===== src/utf8_stream_decoder_top.sv =====
// Top level: input register, configuration register, decode step and result queue.
// An accepted byte is held in the input register and decoded into the queue that feeds out_ch.
// Throughput: one byte per cycle; a byte may give two results, drained at one per cycle
//   if out_ch is ready; the four-entry queue stalls input while fewer than two slots are free.
// Reset (rst_n low, synchronous): no sequence open, queue and input register empty,
//   replacement character back to 63.
module utf8_stream_decoder_top import u8d_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch,
  u8d_cfg_if.sink   cfg_ch
);

  logic             in_vld_r;
  byte_t            byte_r;
  logic             fin_r;
  cp_t              repl_r;
  logic             fire;
  logic [1:0]       push_n;
  res_t             res0, res1;
  logic             busy;
  logic             q_valid;
  res_t             q_head;
  logic [QLvlW-1:0] q_level;

  // Decode the held byte once the queue has room for two beats
  assign fire        = in_vld_r && (q_level <= QLvlW'(QDepth - 2));
  assign in_ch.ready = !in_vld_r || fire;
  assign cfg_ch.ready = 1'b1;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.text_byte;
      fin_r  <= in_ch.final_byte;
    end
  end

  // Replacement character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= ReplReset;
    end else if (cfg_ch.valid) begin
      repl_r <= cfg_ch.replacement_char;
    end
  end

  u8d_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .byte_i (byte_r),
    .fin_i  (fin_r),
    .repl_i (repl_r),
    .n_o    (push_n),
    .res0_o (res0),
    .res1_o (res1),
    .busy_o (busy)
  );

  u8d_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n_i (fire ? push_n : 2'd0),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (out_ch.ready),
    .valid_o  (q_valid),
    .head_o   (q_head),
    .level_o  (q_level)
  );

  // Drive the result channel from the queue head
  assign out_ch.valid      = q_valid;
  assign out_ch.code_point = q_head.code_point;
  assign out_ch.replaced   = q_head.replaced;
  assign out_ch.run_end    = q_head.run_end;
  assign out_ch.text_end   = q_head.text_end;

  // A final byte always leaves the decoder idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && fin_r |=> !busy)
    else $error("decoder still busy after final byte");

  // A final byte always yields at least one result
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && fin_r |-> push_n != 2'd0)
    else $error("final byte produced no result");

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QLvlW'(QDepth))
    else $error("result queue overflow");

  // Reset leaves no sequence open
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_ch.valid)
    else $error("state not cleared by reset");

endmodule
